@@ src/rioc_pkg.sv @@
`default_nettype none

package rioc_pkg;

    // Command codes carried on the opcode field
    typedef enum logic [2:0] {
        OP_POLL      = 3'd0,
        OP_READ      = 3'd1,
        OP_WRITE     = 3'd2,
        OP_WRITE_BIT = 3'd3,
        OP_PULSE     = 3'd4,
        OP_SUBSCRIBE = 3'd5,
        OP_TICK      = 3'd6
    } op_t;

    // Result kinds carried on the kind field
    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_VALUE  = 3'd1,
        KIND_SUB    = 3'd2,
        KIND_CHANGE = 3'd3,
        KIND_ERROR  = 3'd4
    } kind_t;

    // Classified request, as handed from the front end to the executor
    typedef struct packed {
        op_t        op;
        logic [7:0] addr;
        logic       hit_inputs;
        logic       hit_relays;
        logic       num_ok;
        logic [2:0] bit_idx;
        logic [7:0] bit_sel;
        logic [7:0] data;
        logic [7:0] mask;
        logic       lc;
        logic [7:0] ms;
        logic [7:0] inputs;
    } cmd_t;

    // One result item, without last and relay port
    typedef struct packed {
        kind_t      kind;
        logic [7:0] addr;
        logic [7:0] value;
        logic       canc;
    } res_t;

endpackage

`default_nettype wire

@@ src/relay_io_register_controller.sv @@
// Relay and opto-input register block: eight active-low opto inputs, eight relays.
// Request channel (in_valid/in_ready): one command per request, carrying opcode,
// reg_addr, data_value, write_mask, relay_number, level_or_cancel, pulse_ms and
// the raw opto_pins_n sampled with that request.
// Result channel (out_valid/out_ready): each request yields one result, or two
// for a poll that sees both the input byte and the relay byte changed; last
// marks the final result of a request, relay_port_n is the relay drive after it.
// A request goes into the queue first, then its result into the output register.
// Throughput: one request per cycle while out_ready stays high; a two-result poll
// holds the executor until its held second result reaches the output register.
// The front end decodes each request into a short queue (QUEUE_DEPTH entries);
// the executor drains it into one output register plus one hold register.
// When the receiver stalls, the result stays put, the executor stops, and the
// queue fills; in_ready drops only once the queue is full.
// Reset clears all relays, subscriptions, the pulse timer, the queue and the
// output stage; relay_port_n is only meaningful while out_valid is high.
`default_nettype none

module relay_io_register_controller #(
    parameter logic [7:0] ADDR_INPUTS = 8'd0,
    parameter logic [7:0] ADDR_RELAYS = 8'd1,
    parameter int         QUEUE_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] opcode,
    input  wire logic [7:0] reg_addr,
    input  wire logic [7:0] data_value,
    input  wire logic [7:0] write_mask,
    input  wire logic [7:0] relay_number,
    input  wire logic       level_or_cancel,
    input  wire logic [7:0] pulse_ms,
    input  wire logic [7:0] opto_pins_n,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      kind,
    output logic [7:0]      result_addr,
    output logic [7:0]      result_value,
    output logic            cancelled,
    output logic            last,
    output logic [7:0]      relay_port_n
);

    logic           q_full;
    logic           push;
    logic           pop;
    logic           q_valid;
    rioc_pkg::cmd_t push_cmd;
    rioc_pkg::cmd_t head_cmd;

    // Decode and accept requests
    rioc_front #(
        .ADDR_INPUTS(ADDR_INPUTS),
        .ADDR_RELAYS(ADDR_RELAYS)
    ) u_front (
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .reg_addr        (reg_addr),
        .data_value      (data_value),
        .write_mask      (write_mask),
        .relay_number    (relay_number),
        .level_or_cancel (level_or_cancel),
        .pulse_ms        (pulse_ms),
        .opto_pins_n     (opto_pins_n),
        .q_full          (q_full),
        .push            (push),
        .cmd             (push_cmd)
    );

    // Decouple decode from execution
    rioc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head_cmd)
    );

    // Execute against relay, subscription and pulse state; drive results
    rioc_back #(
        .ADDR_INPUTS(ADDR_INPUTS),
        .ADDR_RELAYS(ADDR_RELAYS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .cmd          (head_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .result_addr  (result_addr),
        .result_value (result_value),
        .cancelled    (cancelled),
        .last         (last),
        .relay_port_n (relay_port_n)
    );

endmodule

`default_nettype wire

@@ src/rioc_front.sv @@
`default_nettype none

module rioc_front #(
    parameter logic [7:0] ADDR_INPUTS = 8'd0,
    parameter logic [7:0] ADDR_RELAYS = 8'd1
) (
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [2:0]     opcode,
    input  wire logic [7:0]     reg_addr,
    input  wire logic [7:0]     data_value,
    input  wire logic [7:0]     write_mask,
    input  wire logic [7:0]     relay_number,
    input  wire logic           level_or_cancel,
    input  wire logic [7:0]     pulse_ms,
    input  wire logic [7:0]     opto_pins_n,
    input  wire logic           q_full,
    output logic                push,
    output rioc_pkg::cmd_t      cmd
);

    logic [7:0] inv;
    logic [2:0] idx;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    // Invert the opto pins and swap bits 2 and 3 into logical order
    assign inv = ~opto_pins_n;
    assign idx = relay_number[2:0] - 3'd1;

    always_comb
    begin
        cmd.op         = rioc_pkg::op_t'(opcode);
        cmd.addr       = reg_addr;
        cmd.hit_inputs = (reg_addr == ADDR_INPUTS);
        cmd.hit_relays = (reg_addr == ADDR_RELAYS);
        cmd.num_ok     = (relay_number != 8'd0) && (relay_number <= 8'd8);
        cmd.bit_idx    = idx;
        cmd.bit_sel    = 8'd1 << idx;
        cmd.data       = data_value;
        cmd.mask       = write_mask;
        cmd.lc         = level_or_cancel;
        cmd.ms         = pulse_ms;
        cmd.inputs     = {inv[7:4], inv[2], inv[3], inv[1:0]};
    end

endmodule

`default_nettype wire

@@ src/rioc_queue.sv @@
`default_nettype none

module rioc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire rioc_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                q_valid,
    output rioc_pkg::cmd_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rioc_pkg::cmd_t     mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ src/rioc_back.sv @@
`default_nettype none

module rioc_back #(
    parameter logic [7:0] ADDR_INPUTS = 8'd0,
    parameter logic [7:0] ADDR_RELAYS = 8'd1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire rioc_pkg::cmd_t cmd,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [2:0]          kind,
    output logic [7:0]          result_addr,
    output logic [7:0]          result_value,
    output logic                cancelled,
    output logic                last,
    output logic [7:0]          relay_port_n
);

    // Architectural state
    logic [7:0] relay_reg,     relay_next;
    logic       in_watch_reg,  in_watch_next;
    logic [7:0] in_seen_reg,   in_seen_next;
    logic       rly_watch_reg, rly_watch_next;
    logic [7:0] rly_seen_reg,  rly_seen_next;
    logic       pulse_on_reg,  pulse_on_next;
    logic [7:0] pulse_left_reg, pulse_left_next;
    logic [2:0] pulse_idx_reg, pulse_idx_next;

    // Output stage and the held second result of a poll
    logic                out_valid_reg;
    rioc_pkg::res_t      out_res_reg;
    logic                out_last_reg;
    logic [7:0]          out_port_reg;
    logic                pend_valid_reg;
    rioc_pkg::res_t      pend_res_reg;

    rioc_pkg::res_t      first, second;
    logic                has_second;
    logic                in_chg;
    logic                slot_free;
    logic [7:0]          port_next;

    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = q_valid && slot_free && !pend_valid_reg;

    assign out_valid    = out_valid_reg;
    assign kind         = out_res_reg.kind;
    assign result_addr  = out_res_reg.addr;
    assign result_value = out_res_reg.value;
    assign cancelled    = out_res_reg.canc;
    assign last         = out_last_reg;
    assign relay_port_n = out_port_reg;

    // Active-low relay port: high nibble straight, low nibble reversed
    assign port_next = ~{relay_next[7:4], relay_next[0], relay_next[1],
                         relay_next[2], relay_next[3]};

    always_comb
    begin
        relay_next      = relay_reg;
        in_watch_next   = in_watch_reg;
        in_seen_next    = in_seen_reg;
        rly_watch_next  = rly_watch_reg;
        rly_seen_next   = rly_seen_reg;
        pulse_on_next   = pulse_on_reg;
        pulse_left_next = pulse_left_reg;
        pulse_idx_next  = pulse_idx_reg;
        first      = '{kind: rioc_pkg::KIND_NONE, addr: 8'd0, value: 8'd0, canc: 1'b0};
        second     = first;
        has_second = 1'b0;
        in_chg     = in_watch_reg && (cmd.inputs != in_seen_reg);

        case (cmd.op)
            rioc_pkg::OP_POLL:
            begin
                if (in_chg)
                begin
                    in_seen_next = cmd.inputs;
                    first = '{kind: rioc_pkg::KIND_CHANGE, addr: ADDR_INPUTS,
                              value: cmd.inputs, canc: 1'b0};
                end
                if (rly_watch_reg && (relay_reg != rly_seen_reg))
                begin
                    rly_seen_next = relay_reg;
                    if (in_chg)
                    begin
                        has_second = 1'b1;
                        second = '{kind: rioc_pkg::KIND_CHANGE, addr: ADDR_RELAYS,
                                   value: relay_reg, canc: 1'b0};
                    end
                    else
                    begin
                        first = '{kind: rioc_pkg::KIND_CHANGE, addr: ADDR_RELAYS,
                                  value: relay_reg, canc: 1'b0};
                    end
                end
            end
            rioc_pkg::OP_READ:
            begin
                if (cmd.hit_inputs)
                begin
                    first = '{kind: rioc_pkg::KIND_VALUE, addr: cmd.addr,
                              value: cmd.inputs, canc: 1'b0};
                end
                else if (cmd.hit_relays)
                begin
                    first = '{kind: rioc_pkg::KIND_VALUE, addr: cmd.addr,
                              value: relay_reg, canc: 1'b0};
                end
                else
                begin
                    first = '{kind: rioc_pkg::KIND_ERROR, addr: cmd.addr,
                              value: 8'd0, canc: 1'b0};
                end
            end
            rioc_pkg::OP_WRITE:
            begin
                if (cmd.hit_relays)
                begin
                    relay_next = (relay_reg & ~cmd.mask) | (cmd.data & cmd.mask);
                end
            end
            rioc_pkg::OP_WRITE_BIT:
            begin
                if (cmd.hit_relays && cmd.num_ok)
                begin
                    relay_next = cmd.lc ? (relay_reg | cmd.bit_sel)
                                        : (relay_reg & ~cmd.bit_sel);
                end
            end
            rioc_pkg::OP_PULSE:
            begin
                if (cmd.hit_relays && cmd.num_ok && (cmd.ms != 8'd0) && !pulse_on_reg)
                begin
                    pulse_idx_next  = cmd.bit_idx;
                    pulse_left_next = cmd.ms;
                    pulse_on_next   = 1'b1;
                    relay_next      = relay_reg ^ cmd.bit_sel;
                end
            end
            rioc_pkg::OP_SUBSCRIBE:
            begin
                if (cmd.hit_inputs)
                begin
                    in_watch_next = !cmd.lc;
                    in_seen_next  = cmd.lc ? 8'd0 : cmd.inputs;
                    first = '{kind: rioc_pkg::KIND_SUB, addr: cmd.addr,
                              value: cmd.inputs, canc: cmd.lc};
                end
                else if (cmd.hit_relays)
                begin
                    rly_watch_next = !cmd.lc;
                    rly_seen_next  = cmd.lc ? 8'd0 : relay_reg;
                    first = '{kind: rioc_pkg::KIND_SUB, addr: cmd.addr,
                              value: relay_reg, canc: cmd.lc};
                end
                else
                begin
                    first = '{kind: rioc_pkg::KIND_ERROR, addr: cmd.addr,
                              value: 8'd0, canc: 1'b1};
                end
            end
            rioc_pkg::OP_TICK:
            begin
                if (pulse_on_reg)
                begin
                    pulse_left_next = pulse_left_reg - 8'd1;
                    if (pulse_left_reg == 8'd1)
                    begin
                        relay_next    = relay_reg ^ (8'd1 << pulse_idx_reg);
                        pulse_on_next = 1'b0;
                    end
                end
            end
            default:
            begin
                first = '{kind: rioc_pkg::KIND_NONE, addr: 8'd0, value: 8'd0, canc: 1'b0};
            end
        endcase
    end

    // Commit state only when a request leaves the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg      <= '0;
            in_watch_reg   <= 1'b0;
            in_seen_reg    <= '0;
            rly_watch_reg  <= 1'b0;
            rly_seen_reg   <= '0;
            pulse_on_reg   <= 1'b0;
            pulse_left_reg <= '0;
            pulse_idx_reg  <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                relay_reg      <= relay_next;
                in_watch_reg   <= in_watch_next;
                in_seen_reg    <= in_seen_next;
                rly_watch_reg  <= rly_watch_next;
                rly_seen_reg   <= rly_seen_next;
                pulse_on_reg   <= pulse_on_next;
                pulse_left_reg <= pulse_left_next;
                pulse_idx_reg  <= pulse_idx_next;
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= has_second;
            end
            else if (slot_free && pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; the relay port stays as it was for the held result
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_res_reg  <= first;
            out_last_reg <= !has_second;
            out_port_reg <= port_next;
            pend_res_reg <= second;
        end
        else if (slot_free && pend_valid_reg)
        begin
            out_res_reg  <= pend_res_reg;
            out_last_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire
